>>> src/float_matrix_multiply_accumulate_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply-accumulate block
// Shared concurrent assertion forms, each checked on the rising clock edge
// and disabled while reset is applied.
// ----------------------------------------------------------------------------
`ifndef FLOAT_MATRIX_MULTIPLY_ACCUMULATE_ASSERT_SVH
`define FLOAT_MATRIX_MULTIPLY_ACCUMULATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMMA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fmma_pkg.sv
// ----------------------------------------------------------------------------
// fmma_pkg
// Types, codes and binary32 helper functions shared by the controller and
// the datapath of the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package fmma_pkg;

  localparam int unsigned DEF_MAX_DIM = 64;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned WORD_W      = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_M_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_N_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K_DEPTH = 2'd2;

  localparam logic [CMD_W-1:0] CMD_WR_LEFT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_RIGHT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_RESULT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COMPUTE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RD_RESULT = 3'd4;

  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

  typedef struct packed {
    logic host_write;
    logic wr_left;
    logic wr_right;
    logic wr_result;
    logic host_read;
    logic cnt_clear;
    logic acc_load;
    logic mul_go;
    logic add_go;
    logic norm_lz;
    logic norm_sh;
    logic rnd_prod;
    logic rnd_acc;
    logic k_step;
    logic ij_step;
    logic res_wb;
    logic out_load_zero;
    logic out_load_rd;
    logic out_load_done;
  } fmma_cmd_t;

  typedef struct packed {
    logic in_range;
    logic k_last;
    logic j_last;
    logic i_last;
  } fmma_status_t;

  function automatic logic f32_is_nan(logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic logic f32_is_inf(logic [31:0] x);
    return (&x[30:23]) && !(|x[22:0]);
  endfunction

  function automatic logic f32_is_zero(logic [31:0] x);
    return !(|x[30:0]);
  endfunction

  // Position of the leading one counted from the top; 48 for an all-zero word.
  function automatic logic [5:0] lzc48(logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int b = 0; b < 48; b++) begin
      if (v[b]) begin
        n = 6'(47 - b);
      end
    end
    return n;
  endfunction

  // Rounds a normalized significand (leading one at bit 47) with biased
  // exponent e to nearest even and packs it. The exponent field is formed by
  // adding the rounded significand to (e-1) so that a rounding carry moves
  // into the exponent on its own, also from subnormal into normal range.
  function automatic logic [31:0] round_pack(logic sign, logic signed [10:0] e,
                                             logic [47:0] m);
    logic [47:0]       sm;
    logic              st;
    logic [23:0]       mant;
    logic              g;
    logic              rest;
    logic              rnd;
    logic [31:0]       base;
    logic [31:0]       sum;
    logic signed [10:0] sh;
    sm   = m;
    st   = 1'b0;
    base = '0;
    sh   = 11'sd1 - e;
    if (e >= 11'sd255) begin
      return {sign, 8'hFF, 23'd0};
    end
    if (e >= 11'sd1) begin
      base = {1'b0, e[7:0] - 8'd1, 23'd0};
    end else if (sh >= 11'sd48) begin
      sm = '0;
      st = |m;
    end else begin
      sm = m >> sh[5:0];
      st = |(m & ~({48{1'b1}} << sh[5:0]));
    end
    mant = sm[47:24];
    g    = sm[23];
    rest = st | (|sm[22:0]);
    rnd  = g & (rest | mant[0]);
    sum  = base + {8'd0, mant} + {31'd0, rnd};
    return {sign, sum[30:0]};
  endfunction

endpackage

>>> src/float_matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// float_matrix_multiply_accumulate
// Binary32 matrix multiply-accumulate, result += left * right, driven by
// element write, compute and read requests.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  cfg      in         cfg_we_i                  cfg_index_i, cfg_data_i
//  in       in         in_valid_i / in_ready_o   command, row, column, value
//  out      out        out_valid_o / out_ready_i read_bits, is_read_data, done
//
// An element write or an unknown request loads the result register when it
// is accepted; a read first passes through a wait state for the registered
// read port of the result store. In a compute request, each product and each
// sum goes through the shared normalize-and-round unit in four steps. Reset is
// asynchronous and active low; the stores are not cleared. A result waiting
// in the result register holds off new requests; the next request can be
// taken at the earliest in the cycle in which that result is accepted.
// ----------------------------------------------------------------------------
module float_matrix_multiply_accumulate
  import fmma_pkg::*;
#(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // Request channel.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [IDX_W-1:0]     row_index_i,
  input  logic [IDX_W-1:0]     col_index_i,
  input  logic [WORD_W-1:0]    value_bits_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_W-1:0]    read_bits_o,
  output logic                 is_read_data_o,
  output logic                 compute_done_o
);

  fmma_cmd_t    cmd;
  fmma_status_t status;

  // The controller sequences requests and the compute loops; it never
  // touches payload data.
  fmma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the three stores, the loop counters, the arithmetic
  // and the result register.
  fmma_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .value_bits_i   (value_bits_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .read_bits_o    (read_bits_o),
    .is_read_data_o (is_read_data_o),
    .compute_done_o (compute_done_o)
  );

endmodule

>>> src/fmma_ram.sv
// ----------------------------------------------------------------------------
// fmma_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module fmma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/fmma_datapath.sv
// ----------------------------------------------------------------------------
// fmma_datapath
// Element stores, loop counters, binary32 multiply and add front ends, a
// shared normalize-and-round unit and the result register.
// ----------------------------------------------------------------------------
module fmma_datapath
  import fmma_pkg::*;
#(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [IDX_W-1:0]     row_index_i,
  input  logic [IDX_W-1:0]     col_index_i,
  input  logic [WORD_W-1:0]    value_bits_i,
  input  fmma_cmd_t            cmd_i,
  output fmma_status_t         status_o,
  output logic [WORD_W-1:0]    read_bits_o,
  output logic                 is_read_data_o,
  output logic                 compute_done_o
);

  localparam int unsigned DIM_W  = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W = 2 * DIM_W;
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  logic [CFG_W-1:0] m_rows_q, n_cols_q, k_depth_q;
  logic [DIM_W-1:0] last_i_d, last_j_d, last_k_d;
  logic [DIM_W-1:0] last_i_q, last_j_q, last_k_q;
  logic [DIM_W-1:0] i_q, j_q, k_q;

  logic [8:0]        row_ext, col_ext;
  logic [ADDR_W-1:0] host_addr;
  logic              in_range;
  logic              rd_ok_q;

  logic [ADDR_W-1:0] left_addr, right_addr, res_waddr, res_raddr;
  logic              res_we;
  logic [WORD_W-1:0] res_wdata;
  logic [WORD_W-1:0] left_rd, right_rd, res_rd;

  logic [WORD_W-1:0] acc_q, prod_q;

  // Shared normalize and round stage registers.
  logic               n_spec_q;
  logic [31:0]        n_bits_q;
  logic               n_sign_q;
  logic signed [10:0] n_e_q;
  logic [47:0]        n_m_q;
  logic [5:0]         n_lz_q;

  // Multiply front end.
  logic               mul_spec;
  logic [31:0]        mul_bits;
  logic               mul_sign;
  logic [23:0]        mul_ma, mul_mb;
  logic [7:0]         mul_ea, mul_eb;
  logic [47:0]        mul_p;
  logic signed [10:0] mul_e;

  // Add front end.
  logic               add_spec;
  logic [31:0]        add_bits;
  logic [31:0]        add_x, add_y;
  logic [23:0]        add_mx, add_my;
  logic [7:0]         add_ex, add_ey, add_d;
  logic [26:0]        add_xa, add_ya, add_yal;
  logic [27:0]        add_s;
  logic signed [10:0] add_e;

  logic [31:0] rnd_res;

  assign row_ext   = {3'd0, row_index_i};
  assign col_ext   = {3'd0, col_index_i};
  assign in_range  = (32'(row_ext) < MAX_DIM) && (32'(col_ext) < MAX_DIM);
  assign host_addr = {row_ext[DIM_W-1:0], col_ext[DIM_W-1:0]};

  // Clamp the dimension registers into 1..MAX_DIM and keep the last index.
  always_comb begin
    int dm, dn, dk;
    dm = int'(m_rows_q);
    dn = int'(n_cols_q);
    dk = int'(k_depth_q);
    if (dm < 1) dm = 1;
    if (dn < 1) dn = 1;
    if (dk < 1) dk = 1;
    if (dm > int'(MAX_DIM)) dm = int'(MAX_DIM);
    if (dn > int'(MAX_DIM)) dn = int'(MAX_DIM);
    if (dk > int'(MAX_DIM)) dk = int'(MAX_DIM);
    last_i_d = DIM_W'(dm - 1);
    last_j_d = DIM_W'(dn - 1);
    last_k_d = DIM_W'(dk - 1);
  end

  assign status_o.in_range = in_range;
  assign status_o.k_last   = (k_q == last_k_q);
  assign status_o.j_last   = (j_q == last_j_q);
  assign status_o.i_last   = (i_q == last_i_q);

  assign left_addr  = cmd_i.host_write ? host_addr : {i_q, k_q};
  assign right_addr = cmd_i.host_write ? host_addr : {k_q, j_q};
  assign res_waddr  = cmd_i.host_write ? host_addr : {i_q, j_q};
  assign res_raddr  = cmd_i.host_read  ? host_addr : {i_q, j_q};
  assign res_we     = cmd_i.wr_result | cmd_i.res_wb;
  assign res_wdata  = cmd_i.host_write ? value_bits_i : acc_q;

  fmma_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_left),
    .waddr_i (left_addr),
    .wdata_i (value_bits_i),
    .raddr_i (left_addr),
    .rdata_o (left_rd)
  );

  fmma_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_right),
    .waddr_i (right_addr),
    .wdata_i (value_bits_i),
    .raddr_i (right_addr),
    .rdata_o (right_rd)
  );

  fmma_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_result_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .raddr_i (res_raddr),
    .rdata_o (res_rd)
  );

  // Product of the two operands read from the stores.
  always_comb begin
    mul_sign = left_rd[31] ^ right_rd[31];
    mul_spec = 1'b1;
    mul_bits = '0;
    if (f32_is_nan(left_rd)) begin
      mul_bits = left_rd | QUIET_BIT;
    end else if (f32_is_nan(right_rd)) begin
      mul_bits = right_rd | QUIET_BIT;
    end else if ((f32_is_inf(left_rd) && f32_is_zero(right_rd)) ||
                 (f32_is_inf(right_rd) && f32_is_zero(left_rd))) begin
      mul_bits = DEFAULT_NAN;
    end else if (f32_is_inf(left_rd) || f32_is_inf(right_rd)) begin
      mul_bits = {mul_sign, 8'hFF, 23'd0};
    end else if (f32_is_zero(left_rd) || f32_is_zero(right_rd)) begin
      mul_bits = {mul_sign, 31'd0};
    end else begin
      mul_spec = 1'b0;
    end
    mul_ma = {|left_rd[30:23], left_rd[22:0]};
    mul_mb = {|right_rd[30:23], right_rd[22:0]};
    mul_ea = (left_rd[30:23] == 8'd0) ? 8'd1 : left_rd[30:23];
    mul_eb = (right_rd[30:23] == 8'd0) ? 8'd1 : right_rd[30:23];
    mul_p  = 48'(mul_ma) * 48'(mul_mb);
    mul_e  = 11'(mul_ea) + 11'(mul_eb) - 11'sd126;
  end

  // Sum of the accumulator and the rounded product, aligned with
  // guard, round and sticky bits.
  always_comb begin
    add_spec = 1'b1;
    add_bits = '0;
    if (f32_is_nan(acc_q)) begin
      add_bits = acc_q | QUIET_BIT;
    end else if (f32_is_nan(prod_q)) begin
      add_bits = prod_q | QUIET_BIT;
    end else if (f32_is_inf(acc_q) && f32_is_inf(prod_q) && (acc_q[31] != prod_q[31])) begin
      add_bits = DEFAULT_NAN;
    end else if (f32_is_inf(acc_q)) begin
      add_bits = acc_q;
    end else if (f32_is_inf(prod_q)) begin
      add_bits = prod_q;
    end else if (f32_is_zero(acc_q) && f32_is_zero(prod_q)) begin
      add_bits = {acc_q[31] & prod_q[31], 31'd0};
    end else begin
      add_spec = 1'b0;
    end
    if (prod_q[30:0] > acc_q[30:0]) begin
      add_x = prod_q;
      add_y = acc_q;
    end else begin
      add_x = acc_q;
      add_y = prod_q;
    end
    add_mx  = {|add_x[30:23], add_x[22:0]};
    add_my  = {|add_y[30:23], add_y[22:0]};
    add_ex  = (add_x[30:23] == 8'd0) ? 8'd1 : add_x[30:23];
    add_ey  = (add_y[30:23] == 8'd0) ? 8'd1 : add_y[30:23];
    add_d   = add_ex - add_ey;
    add_xa  = {add_mx, 3'd0};
    add_ya  = {add_my, 3'd0};
    if (add_d >= 8'd27) begin
      add_yal = {26'd0, |add_my};
    end else begin
      add_yal = (add_ya >> add_d[4:0]) |
                {26'd0, |(add_ya & ~({27{1'b1}} << add_d[4:0]))};
    end
    if (add_x[31] == add_y[31]) begin
      add_s = {1'b0, add_xa} + {1'b0, add_yal};
    end else begin
      add_s = {1'b0, add_xa} - {1'b0, add_yal};
    end
    if (!add_spec && (add_s == 28'd0)) begin
      add_spec = 1'b1;
      add_bits = '0;
    end
    add_e = 11'(add_ex) + 11'sd1;
  end

  assign rnd_res = n_spec_q ? n_bits_q : round_pack(n_sign_q, n_e_q, n_m_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_rows_q  <= CFG_RESET;
      n_cols_q  <= CFG_RESET;
      k_depth_q <= CFG_RESET;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      last_i_q  <= '0;
      last_j_q  <= '0;
      last_k_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_M_ROWS:  m_rows_q  <= cfg_data_i;
          REG_N_COLS:  n_cols_q  <= cfg_data_i;
          REG_K_DEPTH: k_depth_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.cnt_clear) begin
        i_q      <= '0;
        j_q      <= '0;
        k_q      <= '0;
        last_i_q <= last_i_d;
        last_j_q <= last_j_d;
        last_k_q <= last_k_d;
      end
      if (cmd_i.k_step) begin
        k_q <= (k_q == last_k_q) ? '0 : k_q + 1'b1;
      end
      if (cmd_i.ij_step) begin
        if (j_q == last_j_q) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.host_read) begin
      rd_ok_q <= in_range;
    end
    if (cmd_i.acc_load) begin
      acc_q <= res_rd;
    end
    if (cmd_i.mul_go) begin
      n_spec_q <= mul_spec;
      n_bits_q <= mul_bits;
      n_sign_q <= mul_sign;
      n_e_q    <= mul_e;
      n_m_q    <= mul_p;
    end
    if (cmd_i.add_go) begin
      n_spec_q <= add_spec;
      n_bits_q <= add_bits;
      n_sign_q <= add_x[31];
      n_e_q    <= add_e;
      n_m_q    <= {add_s, 20'd0};
    end
    if (cmd_i.norm_lz) begin
      n_lz_q <= lzc48(n_m_q);
    end
    if (cmd_i.norm_sh) begin
      n_m_q <= n_m_q << n_lz_q;
      n_e_q <= n_e_q - 11'(n_lz_q);
    end
    if (cmd_i.rnd_prod) begin
      prod_q <= rnd_res;
    end
    if (cmd_i.rnd_acc) begin
      acc_q <= rnd_res;
    end
    if (cmd_i.out_load_zero) begin
      read_bits_o    <= '0;
      is_read_data_o <= 1'b0;
      compute_done_o <= 1'b0;
    end
    if (cmd_i.out_load_rd) begin
      read_bits_o    <= rd_ok_q ? res_rd : '0;
      is_read_data_o <= 1'b1;
      compute_done_o <= 1'b0;
    end
    if (cmd_i.out_load_done) begin
      read_bits_o    <= '0;
      is_read_data_o <= 1'b0;
      compute_done_o <= 1'b1;
    end
  end

endmodule

>>> src/fmma_ctrl.sv
// ----------------------------------------------------------------------------
// fmma_ctrl
// Command decoder and sequencer for element access and the compute loops.
// ----------------------------------------------------------------------------
`include "float_matrix_multiply_accumulate_assert.svh"

module fmma_ctrl
  import fmma_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] command_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  fmma_status_t     status_i,
  output fmma_cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_ACC_RD, S_ACC_LD, S_OP_RD,
    S_MUL, S_MLZ, S_MSH, S_MRND,
    S_ADD, S_ALZ, S_ASH, S_ARND,
    S_WB, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_load;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_load    = cmd_o.out_load_zero | cmd_o.out_load_rd | cmd_o.out_load_done;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_WR_LEFT: begin
              cmd_o.host_write    = 1'b1;
              cmd_o.wr_left       = status_i.in_range;
              cmd_o.out_load_zero = 1'b1;
            end
            CMD_WR_RIGHT: begin
              cmd_o.host_write    = 1'b1;
              cmd_o.wr_right      = status_i.in_range;
              cmd_o.out_load_zero = 1'b1;
            end
            CMD_WR_RESULT: begin
              cmd_o.host_write    = 1'b1;
              cmd_o.wr_result     = status_i.in_range;
              cmd_o.out_load_zero = 1'b1;
            end
            CMD_COMPUTE: begin
              cmd_o.cnt_clear = 1'b1;
              state_d         = S_ACC_RD;
            end
            CMD_RD_RESULT: begin
              cmd_o.host_read = 1'b1;
              state_d         = S_RD_WAIT;
            end
            default: begin
              cmd_o.out_load_zero = 1'b1;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd_o.out_load_rd = 1'b1;
        state_d           = S_IDLE;
      end
      S_ACC_RD: state_d = S_ACC_LD;
      S_ACC_LD: begin
        cmd_o.acc_load = 1'b1;
        state_d        = S_MUL;
      end
      S_OP_RD:  state_d = S_MUL;
      S_MUL: begin
        cmd_o.mul_go = 1'b1;
        state_d      = S_MLZ;
      end
      S_MLZ: begin
        cmd_o.norm_lz = 1'b1;
        state_d       = S_MSH;
      end
      S_MSH: begin
        cmd_o.norm_sh = 1'b1;
        state_d       = S_MRND;
      end
      S_MRND: begin
        cmd_o.rnd_prod = 1'b1;
        state_d        = S_ADD;
      end
      S_ADD: begin
        cmd_o.add_go = 1'b1;
        state_d      = S_ALZ;
      end
      S_ALZ: begin
        cmd_o.norm_lz = 1'b1;
        state_d       = S_ASH;
      end
      S_ASH: begin
        cmd_o.norm_sh = 1'b1;
        state_d       = S_ARND;
      end
      S_ARND: begin
        cmd_o.rnd_acc = 1'b1;
        cmd_o.k_step  = 1'b1;
        state_d       = status_i.k_last ? S_WB : S_OP_RD;
      end
      S_WB: begin
        cmd_o.res_wb  = 1'b1;
        cmd_o.ij_step = 1'b1;
        state_d       = (status_i.i_last && status_i.j_last) ? S_DONE : S_ACC_RD;
      end
      S_DONE: begin
        cmd_o.out_load_done = 1'b1;
        state_d             = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `FMMA_ASSERT_SAME(a_ready_only_idle, clk_i, rst_ni, state_q != S_IDLE, !in_ready_o, "request taken while busy")
  `FMMA_ASSERT_SAME(a_out_load_free, clk_i, rst_ni, out_load, !out_valid_q || out_ready_i, "result register overwritten")
  `FMMA_ASSERT_NEXT(a_last_wb_done, clk_i, rst_ni, state_q == S_WB && status_i.i_last && status_i.j_last, state_q == S_DONE, "compute did not finish after last entry")

endmodule
